[hdl/text_tokenizer_macros.svh]
// Assertion macros shared by the text tokenizer modules.
// Included by the files that carry assertions; no other dependencies.
`ifndef TEXT_TOKENIZER_MACROS_SVH
`define TEXT_TOKENIZER_MACROS_SVH
`ifndef SYNTH
`define TTOK_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text_tokenizer: same-cycle check failed");
`define TTOK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("text_tokenizer: next-cycle check failed");
`else
`define TTOK_ASSERT_IMP(label, clk, rst, ante, cons)
`define TTOK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/ttok_pkg.sv]
// Shared types and constants of the text tokenizer.
// No dependencies; imported by every module of the block.
package ttok_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int LEN_W      = 10;
  localparam int RES_MAX    = 3;
  localparam int RES_CNT_W  = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_CHARS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_COMMA   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRACKET_QUOTES = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_END      = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } ttok_in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       char_value;
    logic [LEN_W-1:0] token_length;
    logic             stream_done;
    logic             last_of_run;
  } ttok_out_t;

  typedef struct packed {
    logic [31:0] break_chars;
    logic [2:0]  break_count;
    logic        ignore_comma;
    logic        bracket_quotes;
  } ttok_cfg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       char_value;
    logic [LEN_W-1:0] token_length;
  } ttok_res_t;

  // All results caused by one input word.
  typedef struct packed {
    ttok_res_t [RES_MAX-1:0] slots;
    logic [RES_CNT_W-1:0]    count;
    logic                    done;
  } ttok_bundle_t;

endpackage

[hdl/ttok_queue.sv]
// Short bundle queue between the tokenizer front and back ends.
// Depends on ttok_pkg.
module ttok_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  ttok_pkg::ttok_bundle_t push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output ttok_pkg::ttok_bundle_t pop_data
);
  import ttok_pkg::*;

  ttok_bundle_t      mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = fill != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[hdl/ttok_front.sv]
// Tokenizer front end: configuration registers, scan state and per-byte decode.
// Depends on ttok_pkg and text_tokenizer_macros.svh.
`include "text_tokenizer_macros.svh"
module ttok_front #(
  parameter int MAX_TOKEN_LENGTH = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [ttok_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttok_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ttok_pkg::ttok_in_t              in_data,
  output logic                            push_valid,
  input  logic                            push_ready,
  output ttok_pkg::ttok_bundle_t          push_data
);
  import ttok_pkg::*;

  localparam int CNT_W = $clog2(MAX_TOKEN_LENGTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TOKEN_LENGTH);

  typedef enum logic [2:0] {
    M_SKIP  = 3'd0,
    M_TOKEN = 3'd1,
    M_LINE  = 3'd2,
    M_BLOCK = 3'd3,
    M_STAR  = 3'd4,
    M_DRAIN = 3'd5
  } mode_t;

  ttok_cfg_t  cfg;
  mode_t      mode;
  logic       quoted;
  logic       held_slash;
  logic       comment_return;
  logic [CNT_W-1:0] token_count;

  mode_t      mode_next;
  logic       quoted_next;
  logic       held_slash_next;
  logic       comment_return_next;
  logic [CNT_W-1:0] token_count_next;

  ttok_res_t [RES_MAX-1:0] res_slots;
  logic [RES_CNT_W-1:0]    res_n;
  logic                    in_comment;
  logic                    accept;

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_break(input ttok_cfg_t k, input logic [7:0] c);
    logic       hit;
    logic [2:0] lim;
    hit = 1'b0;
    lim = (k.break_count > 3'd4) ? 3'd4 : k.break_count;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < lim && k.break_chars[8*i +: 8] == c) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic [LEN_W-1:0] len_of(input logic [CNT_W-1:0] v);
    logic [CNT_W+LEN_W-1:0] w;
    w = {{LEN_W{1'b0}}, v};
    return w[LEN_W-1:0];
  endfunction

  function automatic void emit(input logic [1:0] kind, input logic [7:0] ch,
                               input logic [LEN_W-1:0] len,
                               inout ttok_res_t [RES_MAX-1:0] slots,
                               inout logic [RES_CNT_W-1:0] n);
    if (n != RES_CNT_W'(RES_MAX)) begin
      slots[n] = '{kind: kind, char_value: ch, token_length: len};
      n = n + 1'b1;
    end
  endfunction

  function automatic void end_token(inout mode_t m, inout logic q,
                                    inout logic [CNT_W-1:0] cnt,
                                    inout ttok_res_t [RES_MAX-1:0] slots,
                                    inout logic [RES_CNT_W-1:0] n);
    emit(KIND_END, 8'd0, len_of(cnt), slots, n);
    m   = M_SKIP;
    q   = 1'b0;
    cnt = '0;
  endfunction

  function automatic void token_byte(input ttok_cfg_t k, input logic [7:0] c,
                                     inout mode_t m, inout logic q,
                                     inout logic [CNT_W-1:0] cnt,
                                     inout ttok_res_t [RES_MAX-1:0] slots,
                                     inout logic [RES_CNT_W-1:0] n);
    logic paren;
    logic fin;
    paren = k.bracket_quotes && (c == CH_LPAREN || c == CH_RPAREN);
    fin   = 1'b0;
    if ((!q && is_space(c)) || is_break(k, c)) begin
      end_token(m, q, cnt, slots, n);
    end else begin
      // Quotes are not part of the token text.
      if (c != CH_QUOTE) begin
        if (cnt == CNT_MAX) begin
          emit(KIND_OVERFLOW, 8'd0, '0, slots, n);
          m   = M_DRAIN;
          q   = 1'b0;
          cnt = '0;
          fin = 1'b1;
        end else begin
          emit(KIND_CHAR, c, '0, slots, n);
          cnt = cnt + 1'b1;
        end
      end
      if (!fin && (c == CH_QUOTE || paren)) begin
        if (!q) begin
          q = 1'b1;
        end else if (c == CH_QUOTE) begin
          end_token(m, q, cnt, slots, n);
          fin = 1'b1;
        end else begin
          q = 1'b0;
        end
      end
      if (!fin && !q && c == CH_COMMA && !k.ignore_comma) begin
        end_token(m, q, cnt, slots, n);
      end
    end
  endfunction

  function automatic void plain_byte(input ttok_cfg_t k, input logic [7:0] c,
                                     inout mode_t m, inout logic q,
                                     inout logic [CNT_W-1:0] cnt,
                                     inout ttok_res_t [RES_MAX-1:0] slots,
                                     inout logic [RES_CNT_W-1:0] n);
    if (!(m == M_SKIP && is_space(c) && !is_break(k, c))) begin
      if (m == M_SKIP) begin
        m   = M_TOKEN;
        cnt = '0;
        q   = 1'b0;
      end
      token_byte(k, c, m, q, cnt, slots, n);
    end
  endfunction

  always_comb begin
    mode_next           = mode;
    quoted_next         = quoted;
    held_slash_next     = held_slash;
    comment_return_next = comment_return;
    token_count_next    = token_count;
    res_slots           = '0;
    res_n               = '0;
    case (mode)
      M_LINE: begin
        if (in_data.char_code == CH_NEWLINE) begin
          mode_next = comment_return ? M_TOKEN : M_SKIP;
        end
      end
      M_BLOCK: begin
        if (in_data.char_code == CH_STAR) begin
          mode_next = M_STAR;
        end
      end
      M_STAR: begin
        if (in_data.char_code == CH_SLASH) begin
          mode_next = comment_return ? M_TOKEN : M_SKIP;
        end else if (in_data.char_code != CH_STAR) begin
          mode_next = M_BLOCK;
        end
      end
      M_DRAIN: begin
      end
      default: begin
        if (mode != M_TOKEN) begin
          mode_next = M_SKIP;
        end
        if (held_slash) begin
          held_slash_next = 1'b0;
          if (in_data.char_code == CH_SLASH || in_data.char_code == CH_STAR) begin
            comment_return_next = mode_next == M_TOKEN;
            mode_next = (in_data.char_code == CH_SLASH) ? M_LINE : M_BLOCK;
          end else begin
            // The held slash was not a comment opener: it is an ordinary byte.
            plain_byte(cfg, CH_SLASH, mode_next, quoted_next, token_count_next,
                       res_slots, res_n);
            if (mode_next != M_DRAIN) begin
              plain_byte(cfg, in_data.char_code, mode_next, quoted_next,
                         token_count_next, res_slots, res_n);
            end
          end
        end else if (in_data.char_code == CH_SLASH && !in_data.end_of_text) begin
          held_slash_next = 1'b1;
        end else begin
          plain_byte(cfg, in_data.char_code, mode_next, quoted_next, token_count_next,
                     res_slots, res_n);
        end
      end
    endcase

    in_comment = mode_next == M_LINE || mode_next == M_BLOCK || mode_next == M_STAR;
    if (in_data.end_of_text) begin
      if (mode_next == M_TOKEN || (in_comment && comment_return_next)) begin
        emit(KIND_END, 8'd0, len_of(token_count_next), res_slots, res_n);
      end
      if (res_n == '0) begin
        emit(KIND_END, 8'd0, '0, res_slots, res_n);
      end
      mode_next           = M_SKIP;
      quoted_next         = 1'b0;
      held_slash_next     = 1'b0;
      comment_return_next = 1'b0;
      token_count_next    = '0;
    end
  end

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = in_valid && (res_n != '0);
  assign push_data  = '{slots: res_slots, count: res_n, done: in_data.end_of_text};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg            <= '0;
      mode           <= M_SKIP;
      quoted         <= 1'b0;
      held_slash     <= 1'b0;
      comment_return <= 1'b0;
      token_count    <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_BREAK_CHARS:    cfg.break_chars    <= cfg_wdata;
          REG_BREAK_COUNT:    cfg.break_count    <= cfg_wdata[2:0];
          REG_IGNORE_COMMA:   cfg.ignore_comma   <= cfg_wdata[0];
          REG_BRACKET_QUOTES: cfg.bracket_quotes <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        mode           <= mode_next;
        quoted         <= quoted_next;
        held_slash     <= held_slash_next;
        comment_return <= comment_return_next;
        token_count    <= token_count_next;
      end
    end
  end

  `TTOK_ASSERT_IMP(a_held_slash_mode, clk, rst, held_slash, mode == M_SKIP || mode == M_TOKEN)
  `TTOK_ASSERT_NEXT(a_eot_clears, clk, rst, accept && in_data.end_of_text, mode == M_SKIP && token_count == '0 && !held_slash)
  `TTOK_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, token_count <= CNT_MAX)

endmodule

[hdl/ttok_back.sv]
// Tokenizer back end: unpacks each result bundle onto the output channel.
// Depends on ttok_pkg and text_tokenizer_macros.svh.
`include "text_tokenizer_macros.svh"
module ttok_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  ttok_pkg::ttok_bundle_t pop_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ttok_pkg::ttok_out_t    out_data
);
  import ttok_pkg::*;

  ttok_bundle_t         cur;
  logic                 cur_valid;
  logic [RES_CNT_W-1:0] idx;
  logic                 last;
  logic                 fire;
  logic                 finish;
  logic                 load;

  assign last      = idx == (cur.count - 1'b1);
  assign out_valid = cur_valid;
  assign fire      = out_valid && out_ready;
  assign finish    = fire && last;
  // A new bundle loads in the cycle the last word of the current one leaves.
  assign pop_ready = !cur_valid || finish;
  assign load      = pop_ready && pop_valid;

  assign out_data = '{kind:         cur.slots[idx].kind,
                      char_value:   cur.slots[idx].char_value,
                      token_length: cur.slots[idx].token_length,
                      stream_done:  cur.done,
                      last_of_run:  last};

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (finish) begin
      cur_valid <= 1'b0;
    end else if (fire) begin
      idx <= idx + 1'b1;
    end
  end

  `TTOK_ASSERT_IMP(a_bundle_nonempty, clk, rst, cur_valid, cur.count != '0)
  `TTOK_ASSERT_IMP(a_idx_in_range, clk, rst, cur_valid, idx < cur.count)

endmodule

[hdl/text_tokenizer.sv]
// Text tokenizer: one byte word in per cycle while the queue has room,
// token words out one per cycle while out_ready is high. A byte's result
// words pass through the queue and then the back end's bundle register
// before they are offered. Throughput: one byte per cycle while each byte
// yields at most one word and the output is not stalled.
// Synchronous active-high reset clears the registers, scan state and queue.
module text_tokenizer #(
  parameter int MAX_TOKEN_LENGTH = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [ttok_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttok_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ttok_pkg::ttok_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ttok_pkg::ttok_out_t             out_data
);
  import ttok_pkg::*;

  logic         push_valid;
  logic         push_ready;
  ttok_bundle_t push_data;
  logic         pop_valid;
  logic         pop_ready;
  ttok_bundle_t pop_data;

  ttok_front #(
    .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ttok_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ttok_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
